// ----- rtl/bqm_pkg.sv -----
// Package with the shared types and constants of the bilinear quad mesh generator.
package bqm_pkg;

    localparam int COORD_W = 24;
    localparam int POS_W   = 8;
    localparam int TILE_W  = 5;
    localparam int FRAME_W = 14;
    localparam int DIV_W   = 4;
    localparam int GRID_W  = 3;
    localparam int BDEN_W  = 6;
    localparam int UDEN_W  = 13;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 14;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_COLS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_ROWS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIV_X        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DIV_Y        = 3'd6;

    // Configuration register set as seen by the front and back parts.
    typedef struct packed {
        logic               reverse_mode;
        logic [FRAME_W-1:0] frame_width;
        logic [FRAME_W-1:0] frame_height;
        logic [TILE_W-1:0]  screen_cols;
        logic [TILE_W-1:0]  screen_rows;
        logic [DIV_W-1:0]   div_x;
        logic [DIV_W-1:0]   div_y;
    } cfg_t;

    // One classified face waiting for the back part.
    typedef struct packed {
        logic signed [COORD_W-1:0] tl_x;
        logic signed [COORD_W-1:0] tl_y;
        logic signed [COORD_W-1:0] tr_x;
        logic signed [COORD_W-1:0] tr_y;
        logic signed [COORD_W-1:0] br_x;
        logic signed [COORD_W-1:0] br_y;
        logic signed [COORD_W-1:0] bl_x;
        logic signed [COORD_W-1:0] bl_y;
        logic [POS_W-1:0]          col_pos;
        logic [POS_W-1:0]          row_pos;
        logic [GRID_W-1:0]         span_x;
        logic [GRID_W-1:0]         span_y;
        logic [UDEN_W-1:0]         uden_x;
        logic [UDEN_W-1:0]         uden_y;
    } face_t;

endpackage

// ----- rtl/bilinear_quad_mesh_generator.sv -----
// Top level of the bilinear quad mesh generator: configuration registers, front, queue and back.
//
// Each request on the s_ channel is one projection face: four corners in signed
// Q16.8 and the face's tile position and count. For it the m_ channel delivers
// div_x by div_y grid points in row-major order, last_point marking the final one.
// Both channels use valid and ready; a request is accepted when both are high.
// Configuration is written through cfg_wr_en, cfg_addr and cfg_wdata; the user must do so only
// while idle, as the block itself does not enforce it. The front passes a request combinationally
// into a two-entry queue; the face being worked on stays at the head, so one further face is
// accepted while the back is busy. Each of the div_x by div_y points of a face runs four divisions
// through one shared bit-serial divider of NW = max(32, FRACTION_BITS + 28) steps.
// When the receiver stalls, the finished point waits in the output register and
// the back part holds; the queue keeps accepting until it is full.
// Reset clears the queue, the sequencer and the output valid, and loads the
// registers with their reset values.
module bilinear_quad_mesh_generator
    import bqm_pkg::*;
#(
    parameter int MAX_DIVISIONS = 8,
    parameter int FRACTION_BITS = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      cfg_addr,
    input  logic [CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [COORD_W-1:0] s_top_left_x,
    input  logic signed [COORD_W-1:0] s_top_left_y,
    input  logic signed [COORD_W-1:0] s_top_right_x,
    input  logic signed [COORD_W-1:0] s_top_right_y,
    input  logic signed [COORD_W-1:0] s_bottom_right_x,
    input  logic signed [COORD_W-1:0] s_bottom_right_y,
    input  logic signed [COORD_W-1:0] s_bottom_left_x,
    input  logic signed [COORD_W-1:0] s_bottom_left_y,
    input  logic [POS_W-1:0]          s_column_pos,
    input  logic [POS_W-1:0]          s_row_pos,
    input  logic [TILE_W-1:0]         s_face_cols,
    input  logic [TILE_W-1:0]         s_face_rows,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [GRID_W-1:0]         m_grid_col,
    output logic [GRID_W-1:0]         m_grid_row,
    output logic signed [COORD_W-1:0] m_vertex_x,
    output logic signed [COORD_W-1:0] m_vertex_y,
    output logic signed [COORD_W-1:0] m_texture_x,
    output logic signed [COORD_W-1:0] m_texture_y,
    output logic                      m_last_point
);

    cfg_t  cfg_reg;
    face_t front_face, head_face;
    logic  q_full, q_empty, q_pop, q_push;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reverse_mode <= 1'b0;
            cfg_reg.frame_width  <= FRAME_W'(1920);
            cfg_reg.frame_height <= FRAME_W'(1080);
            cfg_reg.screen_cols  <= TILE_W'(3);
            cfg_reg.screen_rows  <= TILE_W'(1);
            cfg_reg.div_x        <= DIV_W'(2);
            cfg_reg.div_y        <= DIV_W'(2);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_REVERSE:      cfg_reg.reverse_mode <= cfg_wdata[0];
                REG_FRAME_WIDTH:  cfg_reg.frame_width  <= cfg_wdata[FRAME_W-1:0];
                REG_FRAME_HEIGHT: cfg_reg.frame_height <= cfg_wdata[FRAME_W-1:0];
                REG_SCREEN_COLS:  cfg_reg.screen_cols  <= cfg_wdata[TILE_W-1:0];
                REG_SCREEN_ROWS:  cfg_reg.screen_rows  <= cfg_wdata[TILE_W-1:0];
                REG_DIV_X:        cfg_reg.div_x        <= cfg_wdata[DIV_W-1:0];
                REG_DIV_Y:        cfg_reg.div_y        <= cfg_wdata[DIV_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    bqm_front #(
        .MAX_DIVISIONS(MAX_DIVISIONS)
    ) u_front (
        .cfg            (cfg_reg),
        .top_left_x     (s_top_left_x),
        .top_left_y     (s_top_left_y),
        .top_right_x    (s_top_right_x),
        .top_right_y    (s_top_right_y),
        .bottom_right_x (s_bottom_right_x),
        .bottom_right_y (s_bottom_right_y),
        .bottom_left_x  (s_bottom_left_x),
        .bottom_left_y  (s_bottom_left_y),
        .column_pos     (s_column_pos),
        .row_pos        (s_row_pos),
        .face_cols      (s_face_cols),
        .face_rows      (s_face_rows),
        .face           (front_face)
    );

    bqm_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (front_face),
        .pop       (q_pop),
        .head      (head_face),
        .full      (q_full),
        .empty     (q_empty)
    );

    bqm_back #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .face         (head_face),
        .face_avail   (!q_empty),
        .face_pop     (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_grid_col   (m_grid_col),
        .m_grid_row   (m_grid_row),
        .m_vertex_x   (m_vertex_x),
        .m_vertex_y   (m_vertex_y),
        .m_texture_x  (m_texture_x),
        .m_texture_y  (m_texture_y),
        .m_last_point (m_last_point)
    );

endmodule

// ----- rtl/bqm_front.sv -----
// Front part: accepts a face request and works out its per-face spans and divisors.
module bqm_front
    import bqm_pkg::*;
#(
    parameter int MAX_DIVISIONS = 8
) (
    input  cfg_t                      cfg,
    input  logic signed [COORD_W-1:0] top_left_x,
    input  logic signed [COORD_W-1:0] top_left_y,
    input  logic signed [COORD_W-1:0] top_right_x,
    input  logic signed [COORD_W-1:0] top_right_y,
    input  logic signed [COORD_W-1:0] bottom_right_x,
    input  logic signed [COORD_W-1:0] bottom_right_y,
    input  logic signed [COORD_W-1:0] bottom_left_x,
    input  logic signed [COORD_W-1:0] bottom_left_y,
    input  logic [POS_W-1:0]          column_pos,
    input  logic [POS_W-1:0]          row_pos,
    input  logic [TILE_W-1:0]         face_cols,
    input  logic [TILE_W-1:0]         face_rows,
    output face_t                     face
);

    localparam logic [DIV_W-1:0] DIV_MAX = DIV_W'(MAX_DIVISIONS);
    localparam logic [DIV_W-1:0] DIV_MIN = 4'd2;

    logic [DIV_W-1:0]  dx, dy;
    logic [TILE_W-1:0] fc, fr, sc, sr;

    // Clamp the division counts and replace zero tile counts by one.
    always_comb begin
        dx = cfg.div_x;
        if (cfg.div_x < DIV_MIN) dx = DIV_MIN;
        if (cfg.div_x > DIV_MAX) dx = DIV_MAX;
        dy = cfg.div_y;
        if (cfg.div_y < DIV_MIN) dy = DIV_MIN;
        if (cfg.div_y > DIV_MAX) dy = DIV_MAX;
        fc = (face_cols == '0) ? TILE_W'(1) : face_cols;
        fr = (face_rows == '0) ? TILE_W'(1) : face_rows;
        sc = (cfg.screen_cols == '0) ? TILE_W'(1) : cfg.screen_cols;
        sr = (cfg.screen_rows == '0) ? TILE_W'(1) : cfg.screen_rows;
    end

    // Build the queue entry.
    always_comb begin
        face.tl_x    = top_left_x;
        face.tl_y    = top_left_y;
        face.tr_x    = top_right_x;
        face.tr_y    = top_right_y;
        face.br_x    = bottom_right_x;
        face.br_y    = bottom_right_y;
        face.bl_x    = bottom_left_x;
        face.bl_y    = bottom_left_y;
        face.col_pos = column_pos;
        face.row_pos = row_pos;
        face.span_x  = GRID_W'(dx - DIV_W'(1));
        face.span_y  = GRID_W'(dy - DIV_W'(1));
        face.uden_x  = UDEN_W'(UDEN_W'(face.span_x) * UDEN_W'(fc) * UDEN_W'(sc));
        face.uden_y  = UDEN_W'(UDEN_W'(face.span_y) * UDEN_W'(fr) * UDEN_W'(sr));
    end

endmodule

// ----- rtl/bqm_fifo.sv -----
// Two-entry queue of classified faces between the front and back parts.
module bqm_fifo
    import bqm_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  face_t push_data,
    input  logic  pop,
    output face_t head,
    output logic  full,
    output logic  empty
);

    face_t      mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = mem[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)      count_reg <= count_reg + 2'd1;
            else if (pop && !push) count_reg <= count_reg - 2'd1;
        end
    end

endmodule

// ----- rtl/bqm_div.sv -----
// Iterative divider giving a rounded, saturated 24-bit quotient, one bit a cycle.
module bqm_div
    import bqm_pkg::*;
#(
    parameter int NW = 36,
    parameter int DW = 14
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic signed [NW-1:0]      num,
    input  logic [DW-1:0]             den,
    output logic                      done,
    output logic signed [COORD_W-1:0] quo
);

    localparam int CW = $clog2(NW + 1);

    logic                 busy_reg, fin_reg, done_reg;
    logic [CW-1:0]        cnt_reg;
    logic [NW-1:0]        q_reg;
    logic [DW-1:0]        rem_reg, den_reg;
    logic                 neg_reg;
    logic signed [COORD_W-1:0] quo_reg;

    logic [DW:0]          rem_sh;
    logic                 fits;
    logic [NW:0]          qa;

    assign done = done_reg;
    assign quo  = quo_reg;

    always_comb begin
        rem_sh = {rem_reg, q_reg[NW-1]};
        fits   = (rem_sh >= {1'b0, den_reg});
        qa     = {1'b0, q_reg} + (NW+1)'(neg_reg && (rem_reg != '0));
    end

    // Shift-subtract loop, then sign fix and saturation.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
                neg_reg  <= num[NW-1];
                q_reg    <= num[NW-1] ? NW'(-num) : NW'(num);
                rem_reg  <= '0;
                den_reg  <= den;
            end else if (busy_reg) begin
                rem_reg <= fits ? DW'(rem_sh - {1'b0, den_reg}) : DW'(rem_sh);
                q_reg   <= {q_reg[NW-2:0], fits};
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end else if (fin_reg) begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
                if (!neg_reg && qa > (NW+1)'(8388607)) begin
                    quo_reg <= COORD_MAX;
                end else if (neg_reg && qa > (NW+1)'(8388608)) begin
                    quo_reg <= COORD_MIN;
                end else if (neg_reg) begin
                    quo_reg <= COORD_W'(-qa);
                end else begin
                    quo_reg <= COORD_W'(qa);
                end
            end
        end
    end

endmodule

// ----- rtl/bqm_back.sv -----
// Back part: walks the grid of a face and computes each point through the shared divider.
module bqm_back
    import bqm_pkg::*;
#(
    parameter int FRACTION_BITS = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cfg_t                      cfg,
    input  face_t                     face,
    input  logic                      face_avail,
    output logic                      face_pop,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [GRID_W-1:0]         m_grid_col,
    output logic [GRID_W-1:0]         m_grid_row,
    output logic signed [COORD_W-1:0] m_vertex_x,
    output logic signed [COORD_W-1:0] m_vertex_y,
    output logic signed [COORD_W-1:0] m_texture_x,
    output logic signed [COORD_W-1:0] m_texture_y,
    output logic                      m_last_point
);

    localparam int NW = (28 + FRACTION_BITS > 32) ? 28 + FRACTION_BITS : 32;
    localparam int DW = UDEN_W + 1;
    localparam int PW = POS_W + GRID_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_WGT  = 3'd1;
    localparam logic [2:0] ST_JOB  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]          state_reg;
    logic [GRID_W-1:0]   gx_reg, gy_reg;
    logic [1:0]          job_reg;
    logic [BDEN_W-1:0]   wa_reg, wb_reg, wc_reg, wd_reg, bden_reg;
    logic [PW-1:0]       px_reg, py_reg;
    logic signed [COORD_W-1:0] res_reg [4];

    logic                m_valid_reg, last_reg;
    logic [GRID_W-1:0]   col_reg, row_reg;
    logic signed [COORD_W-1:0] vx_reg, vy_reg, tx_reg, ty_reg;

    logic signed [COORD_W-1:0] c_tl, c_tr, c_br, c_bl;
    logic signed [NW-1:0] n_b, n_u, div_num;
    logic [DW-1:0]        div_den;
    logic [FRAME_W-1:0]   frame;
    logic [PW-1:0]        p_sel;
    logic [UDEN_W-1:0]    uden;
    logic                 div_start, div_done, out_free, at_last;
    logic signed [COORD_W-1:0] div_quo;

    assign out_free = !m_valid_reg || m_ready;
    assign at_last  = (gx_reg == face.span_x) && (gy_reg == face.span_y);
    assign div_start = (state_reg == ST_JOB);
    assign face_pop  = (state_reg == ST_OUT) && out_free && at_last;

    // Numerator and divisor of the current job: warped x, warped y, uniform x, uniform y.
    always_comb begin
        c_tl  = job_reg[0] ? face.tl_y : face.tl_x;
        c_tr  = job_reg[0] ? face.tr_y : face.tr_x;
        c_br  = job_reg[0] ? face.br_y : face.br_x;
        c_bl  = job_reg[0] ? face.bl_y : face.bl_x;
        frame = job_reg[0] ? cfg.frame_height : cfg.frame_width;
        p_sel = job_reg[0] ? py_reg : px_reg;
        uden  = job_reg[0] ? face.uden_y : face.uden_x;
        n_b = NW'(NW'(c_tl) * NW'($signed({1'b0, wa_reg})))
            + NW'(NW'(c_tr) * NW'($signed({1'b0, wb_reg})))
            + NW'(NW'(c_br) * NW'($signed({1'b0, wc_reg})))
            + NW'(NW'(c_bl) * NW'($signed({1'b0, wd_reg})));
        n_b = NW'((n_b <<< 1) + $signed(NW'(bden_reg)));
        n_u = $signed(NW'((NW'(NW'(frame) * NW'(p_sel)) << (FRACTION_BITS + 1))
            + NW'(uden)));
        if (job_reg[1]) begin
            div_num = n_u;
            div_den = {uden, 1'b0};
        end else begin
            div_num = n_b;
            div_den = DW'({bden_reg, 1'b0});
        end
    end

    bqm_div #(
        .NW(NW),
        .DW(DW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    // Point sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            gx_reg    <= '0;
            gy_reg    <= '0;
            job_reg   <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    gx_reg <= '0;
                    gy_reg <= '0;
                    if (face_avail) state_reg <= ST_WGT;
                end
                ST_WGT: begin
                    job_reg   <= '0;
                    state_reg <= ST_JOB;
                end
                ST_JOB: begin
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_done) begin
                        job_reg <= job_reg + 2'd1;
                        state_reg <= (job_reg == 2'd3) ? ST_OUT : ST_JOB;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        if (at_last) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            state_reg <= ST_WGT;
                            if (gx_reg == face.span_x) begin
                                gx_reg <= '0;
                                gy_reg <= gy_reg + GRID_W'(1);
                            end else begin
                                gx_reg <= gx_reg + GRID_W'(1);
                            end
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Bilinear weights and uniform offsets of the current point.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_WGT) begin
            wa_reg   <= BDEN_W'(BDEN_W'(face.span_x - gx_reg) * BDEN_W'(face.span_y - gy_reg));
            wb_reg   <= BDEN_W'(BDEN_W'(gx_reg) * BDEN_W'(face.span_y - gy_reg));
            wc_reg   <= BDEN_W'(BDEN_W'(gx_reg) * BDEN_W'(gy_reg));
            wd_reg   <= BDEN_W'(BDEN_W'(face.span_x - gx_reg) * BDEN_W'(gy_reg));
            bden_reg <= BDEN_W'(BDEN_W'(face.span_x) * BDEN_W'(face.span_y));
            px_reg   <= PW'(PW'(face.col_pos) * PW'(face.span_x) + PW'(gx_reg));
            py_reg   <= PW'(PW'(face.row_pos) * PW'(face.span_y) + PW'(gy_reg));
        end
        if (state_reg == ST_DIV && div_done) begin
            res_reg[job_reg] <= div_quo;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_free) begin
            col_reg  <= gx_reg;
            row_reg  <= gy_reg;
            last_reg <= at_last;
            if (cfg.reverse_mode) begin
                vx_reg <= res_reg[2];
                vy_reg <= res_reg[3];
                tx_reg <= res_reg[0];
                ty_reg <= res_reg[1];
            end else begin
                vx_reg <= res_reg[0];
                vy_reg <= res_reg[1];
                tx_reg <= res_reg[2];
                ty_reg <= res_reg[3];
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_grid_col   = col_reg;
    assign m_grid_row   = row_reg;
    assign m_vertex_x   = vx_reg;
    assign m_vertex_y   = vy_reg;
    assign m_texture_x  = tx_reg;
    assign m_texture_y  = ty_reg;
    assign m_last_point = last_reg;

endmodule
